/* rtl/sse_pkg.sv */
`default_nettype none

package sse_pkg;

	// Largest pattern the window can hold.
	localparam int MaxPattern = 16;

	// Field widths of the configuration registers and the stream words.
	localparam int CfgDataW    = 64;
	localparam int CfgIndexW   = 3;
	localparam int PatternW    = 128;
	localparam int PatLenW     = 5;
	localparam int BoundW      = 17;
	localparam int TextLenW    = 16;
	localparam int ByteW       = 8;
	localparam int PositionW   = 16;
	localparam int InDataW     = 8;
	localparam int OutDataW    = 24;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexW-1:0] RegPatternLow  = 3'd0;
	localparam logic [CfgIndexW-1:0] RegPatternHigh = 3'd1;
	localparam logic [CfgIndexW-1:0] RegPatternLen  = 3'd2;
	localparam logic [CfgIndexW-1:0] RegFoldCase    = 3'd3;
	localparam logic [CfgIndexW-1:0] RegReverse     = 3'd4;
	localparam logic [CfgIndexW-1:0] RegBound       = 3'd5;
	localparam logic [CfgIndexW-1:0] RegTextLen     = 3'd6;

	// ASCII upper case range and the offset to lower case.
	localparam logic [ByteW-1:0] UpperFirst = 8'h41;
	localparam logic [ByteW-1:0] UpperLast  = 8'h5A;
	localparam logic [ByteW-1:0] CaseOffset = 8'h20;

	// Settings seen by the matcher; limit is the already resolved bound.
	typedef struct packed {
		logic [PatternW-1:0]  pattern;
		logic [PatLenW-1:0]   pattern_len;
		logic                 fold_case;
		logic                 reverse;
		logic [TextLenW-1:0]  limit;
		logic [TextLenW-1:0]  text_len;
	} cfg_t;

	// Outcome of the search as it stands after the current word.
	typedef struct packed {
		logic                 found;
		logic [PositionW-1:0] position;
	} result_t;

	function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] c,
		input logic en);
		if (en && c >= UpperFirst && c <= UpperLast) begin
			return c + CaseOffset;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/sse_cfg.sv */
`default_nettype none

module sse_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [sse_pkg::CfgIndexW-1:0]    cfg_index,
	input  wire logic [sse_pkg::CfgDataW-1:0]     cfg_data,
	output sse_pkg::cfg_t                         cfg
);

	logic [sse_pkg::CfgDataW-1:0]  pattern_low_q;
	logic [sse_pkg::CfgDataW-1:0]  pattern_high_q;
	logic [sse_pkg::PatLenW-1:0]   pattern_len_q;
	logic                          fold_case_q;
	logic                          reverse_q;
	logic [sse_pkg::BoundW-1:0]    bound_q;
	logic [sse_pkg::TextLenW-1:0]  text_len_q;
	logic signed [sse_pkg::TextLenW+1:0] back_sum;
	logic [sse_pkg::TextLenW-1:0]  limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= '0;
			fold_case_q    <= 1'b0;
			reverse_q      <= 1'b0;
			bound_q        <= '0;
			text_len_q     <= sse_pkg::TextLenW'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sse_pkg::RegPatternLow:  pattern_low_q  <= cfg_data;
				sse_pkg::RegPatternHigh: pattern_high_q <= cfg_data;
				sse_pkg::RegPatternLen:  pattern_len_q  <= cfg_data[sse_pkg::PatLenW-1:0];
				sse_pkg::RegFoldCase:    fold_case_q    <= cfg_data[0];
				sse_pkg::RegReverse:     reverse_q      <= cfg_data[0];
				sse_pkg::RegBound:       bound_q        <= cfg_data[sse_pkg::BoundW-1:0];
				sse_pkg::RegTextLen:     text_len_q     <= cfg_data[sse_pkg::TextLenW-1:0];
				default: ;
			endcase
		end
	end

	// A negative bound counts back from the text length and stops at zero;
	// a positive one is capped at the text length.
	always_comb begin
		back_sum = $signed({2'b00, text_len_q}) + $signed({bound_q[sse_pkg::BoundW-1], bound_q});
		if (bound_q[sse_pkg::BoundW-1]) begin
			limit = back_sum[sse_pkg::TextLenW+1] ? '0 : back_sum[sse_pkg::TextLenW-1:0];
		end else begin
			limit = (bound_q[sse_pkg::TextLenW-1:0] < text_len_q) ?
				bound_q[sse_pkg::TextLenW-1:0] : text_len_q;
		end
	end

	always_comb begin
		cfg.pattern     = {pattern_high_q, pattern_low_q};
		cfg.pattern_len = pattern_len_q;
		cfg.fold_case   = fold_case_q;
		cfg.reverse     = reverse_q;
		cfg.limit       = limit;
		cfg.text_len    = text_len_q;
	end

endmodule

`default_nettype wire

/* rtl/sse_match.sv */
`default_nettype none

module sse_match #(
	parameter int MAX_PATTERN = sse_pkg::MaxPattern
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [sse_pkg::ByteW-1:0]   text_byte,
	input  wire logic                        last,
	input  wire sse_pkg::cfg_t               cfg,
	output sse_pkg::result_t                 res
);

	localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [sse_pkg::ByteW-1:0]     window_q [MAX_PATTERN];
	logic [sse_pkg::ByteW-1:0]     win_next [MAX_PATTERN];
	logic [sse_pkg::TextLenW-1:0]  count_q;
	logic                          hit_q;
	logic [sse_pkg::PositionW-1:0] offset_q;

	logic                          all_eq;
	logic [sse_pkg::PatLenW-1:0]   sel;
	logic                          plen_ok;
	logic                          long_enough;
	logic [sse_pkg::TextLenW:0]    end_plus1;
	logic [sse_pkg::PositionW-1:0] start;
	logic                          cand;
	logic                          hit_next;
	logic [sse_pkg::PositionW-1:0] offset_next;

	always_comb begin
		win_next[0] = text_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_next[i] = window_q[i-1];
		end

		// Pattern byte k lines up with the window tap plen-1-k.
		all_eq = 1'b1;
		sel    = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (sse_pkg::PatLenW'(k) < cfg.pattern_len) begin
				sel = cfg.pattern_len - sse_pkg::PatLenW'(1) - sse_pkg::PatLenW'(k);
				if (sse_pkg::fold_byte(cfg.pattern[8*k +: 8], cfg.fold_case) !=
					sse_pkg::fold_byte(win_next[sel[IdxW-1:0]], cfg.fold_case)) begin
					all_eq = 1'b0;
				end
			end
		end

		plen_ok     = (cfg.pattern_len != '0) &&
			(cfg.pattern_len <= sse_pkg::PatLenW'(MAX_PATTERN));
		end_plus1   = {1'b0, count_q} + (sse_pkg::TextLenW+1)'(1);
		long_enough = end_plus1 >= (sse_pkg::TextLenW+1)'(cfg.pattern_len);
		start       = sse_pkg::PositionW'(end_plus1 -
			(sse_pkg::TextLenW+1)'(cfg.pattern_len));
		cand        = plen_ok && (count_q < cfg.text_len) && long_enough && all_eq;

		hit_next    = hit_q;
		offset_next = offset_q;
		if (cand) begin
			if (cfg.reverse) begin
				if (start < cfg.limit) begin
					hit_next    = 1'b1;
					offset_next = start;
				end
			end else if (!hit_q && start >= cfg.limit) begin
				hit_next    = 1'b1;
				offset_next = start;
			end
		end

		res.found    = hit_next;
		res.position = hit_next ? offset_next : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_q[i] <= '0;
			end
			count_q  <= '0;
			hit_q    <= 1'b0;
			offset_q <= '0;
		end else if (step) begin
			if (last) begin
				for (int i = 0; i < MAX_PATTERN; i++) begin
					window_q[i] <= '0;
				end
				count_q  <= '0;
				hit_q    <= 1'b0;
				offset_q <= '0;
			end else begin
				for (int i = 0; i < MAX_PATTERN; i++) begin
					window_q[i] <= win_next[i];
				end
				if (count_q != '1) begin
					count_q <= count_q + sse_pkg::TextLenW'(1);
				end
				hit_q    <= hit_next;
				offset_q <= offset_next;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/substring_search_engine.sv */
// Path: a word accepted into the input stage register is compared from there by the
// combinational window compare; a last word loads the result word shown on m_tvalid.
// Throughput: one text word per cycle unless a last byte waits on a held result.
// Reset (arst_n low, asynchronous): registers take their reset values (text_len 1),
// the window, byte count and kept match clear, and both stream sides go empty.
`default_nettype none

module substring_search_engine #(
	parameter int MAX_PATTERN = sse_pkg::MaxPattern
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// Configuration write port.
	input  wire logic                           cfg_wr_en,
	input  wire logic [sse_pkg::CfgIndexW-1:0]  cfg_index,
	input  wire logic [sse_pkg::CfgDataW-1:0]   cfg_data,

	// Text stream.
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [sse_pkg::InDataW-1:0]    s_tdata,   // [7:0] text_byte
	input  wire logic                           s_tlast,   // last byte of the text

	// Result stream.
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [sse_pkg::OutDataW-1:0]   m_tdata    // [0] found, [16:1] position,
	                                                       // [23:17] zero
);

	sse_pkg::cfg_t    cfg;
	sse_pkg::result_t res;

	// Input stage register.
	logic                       valid_s1;
	logic [sse_pkg::ByteW-1:0]  byte_s1;
	logic                       last_s1;

	// Result register.
	logic                           out_valid_q;
	logic                           found_q;
	logic [sse_pkg::PositionW-1:0]  position_q;

	logic advance;
	logic out_load;

	sse_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A word in the input stage moves on unless it is the last byte and the
	// result register is still held by the sink. Ordinary bytes keep flowing
	// while an earlier result waits to be taken.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign out_load = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[sse_pkg::ByteW-1:0];
			last_s1 <= s_tlast;
		end
	end

	sse_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (byte_s1),
		.last      (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// The result register fills on the last byte and empties when the sink
	// takes it; a load and a take in the same cycle keep it full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q    <= res.found;
			position_q <= res.position;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(sse_pkg::OutDataW-sse_pkg::PositionW-1)'(0), position_q, found_q};

endmodule

`default_nettype wire
